// ===== src/assert_macros.svh =====
// Assertion macros used by the decoder datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/hedsc_pkg.sv =====
// Shared types, entity name table and command codes for the entity decoder.
`timescale 1ns / 1ps

package hedsc_pkg;

    localparam int NUM_NAMES    = 8;
    localparam int NAME_MAX_LEN = 4;
    localparam int MAX_RESULTS  = 12;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // entity names, first character at index 0
    localparam logic [7:0] NAME_CHAR [NUM_NAMES][NAME_MAX_LEN] = '{
        '{"a", "m", "p", 8'h00},
        '{"q", "u", "o", "t"},
        '{"l", "t", 8'h00, 8'h00},
        '{"g", "t", 8'h00, 8'h00},
        '{"a", "p", "o", "s"},
        '{"n", "b", "s", "p"},
        '{"#", "x", "2", "7"},
        '{"#", "3", "9", 8'h00}
    };

    localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{
        3'd3, 3'd4, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd3
    };

    localparam logic [7:0] NAME_VALUE [NUM_NAMES] = '{
        8'h26, 8'h22, 8'h3C, 8'h3E, 8'h27, 8'h20, 8'h27, 8'h27
    };

    // byte source for a decode step, or a forced window failure
    localparam logic [1:0] MODE_INPUT = 2'd0;
    localparam logic [1:0] MODE_QUEUE = 2'd1;
    localparam logic [1:0] MODE_FORCE = 2'd2;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       flush;
        logic [1:0] mode;
    } dp_cmd_t;

    typedef struct packed {
        logic queue_empty;
        logic in_entity;
        logic item_last;
        logic space_only;
        logic slot_ok;
        logic flush_ok;
    } dp_status_t;

endpackage

// ===== src/hedsc_datapath.sv =====
// Entity window, replay queue, whitespace folding and output registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hedsc_datapath #(
    parameter int MAX_ENTITY_SPAN = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hedsc_pkg::dp_cmd_t    cmd,
    output hedsc_pkg::dp_status_t status,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output logic                  out_valid,
    output logic [7:0]            out_byte,
    output logic                  out_byte_valid,
    output logic                  out_last,
    input  logic                  out_ready
);

    localparam int WIN_DEPTH = MAX_ENTITY_SPAN - 1;
    localparam int PW        = $clog2(MAX_ENTITY_SPAN);
    localparam int BUF_DEPTH = 1 << PW;
    localparam int CMP_W     = PW + 3;

    // held bytes of the open window followed by the replay queue, circular
    logic [7:0] win_mem [BUF_DEPTH];

    logic [7:0]                      item_byte_reg;
    logic                            item_last_reg;
    logic                            in_entity_reg, in_entity_next;
    logic [PW-1:0]                   wcount_reg, wcount_next;
    logic [hedsc_pkg::NUM_NAMES-1:0] cand_reg, cand_next;
    logic [PW-1:0]                   wstart_reg, wstart_next;
    logic [PW-1:0]                   rd_reg, rd_next;
    logic [PW-1:0]                   wr_reg, wr_next;
    logic                            pending_reg, pending_next;
    logic                            seen_reg, seen_next;
    logic [hedsc_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                            hold_valid_reg, hold_valid_next;
    logic [7:0]                      hold_byte_reg, hold_byte_next;
    logic                            out_valid_reg, out_valid_next;
    logic [7:0]                      out_byte_reg, out_byte_next;
    logic                            out_bvalid_reg, out_bvalid_next;
    logic                            out_last_reg, out_last_next;
    logic [7:0]                      rd_data_reg;
    logic                            fwd_reg;
    logic [7:0]                      fwd_byte_reg;

    logic                            from_queue;
    logic                            force_fail;
    logic [7:0]                      queue_byte;
    logic [7:0]                      cur_byte;
    logic [PW-1:0]                   rd_inc;
    logic [PW-1:0]                   wcount_inc;
    logic [hedsc_pkg::NUM_NAMES-1:0] cand_upd;
    logic                            name_hit;
    logic [7:0]                      hit_value;

    logic                            dec_in_entity;
    logic [PW-1:0]                   dec_wcount;
    logic [hedsc_pkg::NUM_NAMES-1:0] dec_cand;
    logic [PW-1:0]                   dec_wstart;
    logic [PW-1:0]                   dec_rd;
    logic [PW-1:0]                   dec_wr;
    logic                            dec_wr_en;
    logic                            emit_req;
    logic [7:0]                      emit_char;

    logic                            emit_visible;
    logic                            space_only;
    logic [7:0]                      res_char;
    logic                            keep;
    logic                            out_free;
    logic                            out_push;
    logic                            mem_we;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // read data is registered at the address rd takes next; a byte written there is forwarded
    assign from_queue = (cmd.mode == hedsc_pkg::MODE_QUEUE);
    assign force_fail = (cmd.mode == hedsc_pkg::MODE_FORCE);
    assign queue_byte = fwd_reg ? fwd_byte_reg : rd_data_reg;
    assign cur_byte   = from_queue ? queue_byte : item_byte_reg;
    assign rd_inc     = rd_reg + PW'(1);
    assign wcount_inc = wcount_reg + PW'(1);

    // incremental name match, one candidate bit per entity name
    always_comb
    begin
        cand_upd  = '0;
        name_hit  = 1'b0;
        hit_value = '0;
        for (int i = 0; i < hedsc_pkg::NUM_NAMES; i++)
        begin
            if (cand_reg[i] && (CMP_W'(wcount_reg) < CMP_W'(hedsc_pkg::NAME_LEN[i])) &&
                (hedsc_pkg::NAME_CHAR[i][wcount_reg[1:0]] == cur_byte))
            begin
                cand_upd[i] = 1'b1;
            end
            if (cand_reg[i] && (CMP_W'(wcount_reg) == CMP_W'(hedsc_pkg::NAME_LEN[i])))
            begin
                name_hit  = 1'b1;
                hit_value = hedsc_pkg::NAME_VALUE[i];
            end
        end
    end

    // one decode step on cur_byte, or a forced window failure
    always_comb
    begin
        dec_in_entity = in_entity_reg;
        dec_wcount    = wcount_reg;
        dec_cand      = cand_reg;
        dec_wstart    = wstart_reg;
        dec_rd        = rd_reg;
        dec_wr        = wr_reg;
        dec_wr_en     = 1'b0;
        emit_req      = 1'b0;
        emit_char     = cur_byte;
        if (force_fail)
        begin
            emit_req      = 1'b1;
            emit_char     = hedsc_pkg::CHAR_AMP;
            dec_in_entity = 1'b0;
            dec_wcount    = '0;
            dec_rd        = wstart_reg;
        end
        else if (!in_entity_reg)
        begin
            dec_rd = from_queue ? rd_inc : rd_reg;
            if (cur_byte == hedsc_pkg::CHAR_AMP)
            begin
                dec_in_entity = 1'b1;
                dec_wcount    = '0;
                dec_cand      = '1;
                dec_wstart    = from_queue ? rd_inc : rd_reg;
            end
            else
            begin
                emit_req = 1'b1;
            end
        end
        else if (cur_byte == hedsc_pkg::CHAR_SEMI && name_hit)
        begin
            emit_req      = 1'b1;
            emit_char     = hit_value;
            dec_in_entity = 1'b0;
            dec_wcount    = '0;
            dec_rd        = from_queue ? rd_inc : rd_reg;
        end
        else
        begin
            dec_wcount = wcount_inc;
            dec_cand   = cand_upd;
            dec_rd     = rd_inc;
            if (!from_queue)
            begin
                dec_wr_en = 1'b1;
                dec_wr    = wr_reg + PW'(1);
            end
            if (cur_byte == hedsc_pkg::CHAR_SEMI || wcount_inc == PW'(WIN_DEPTH))
            begin
                emit_req      = 1'b1;
                emit_char     = hedsc_pkg::CHAR_AMP;
                dec_in_entity = 1'b0;
                dec_wcount    = '0;
                dec_rd        = wstart_reg;
            end
        end
    end

    assign emit_visible = emit_req && !is_ws(emit_char);
    assign space_only   = emit_visible && pending_reg;
    assign res_char     = space_only ? hedsc_pkg::CHAR_SPACE : emit_char;
    assign keep         = cmd.step && emit_visible &&
                          (cnt_reg < hedsc_pkg::CNT_W'(hedsc_pkg::MAX_RESULTS));
    assign out_free     = !out_valid_reg || out_ready;
    assign out_push     = (keep && hold_valid_reg) ||
                          (cmd.flush && (hold_valid_reg || item_last_reg));
    assign mem_we       = cmd.step && !space_only && dec_wr_en;

    always_comb
    begin
        status.queue_empty = (rd_reg == wr_reg);
        status.in_entity   = in_entity_reg;
        status.item_last   = item_last_reg;
        status.space_only  = space_only;
        status.slot_ok     = !(emit_visible &&
                               (cnt_reg < hedsc_pkg::CNT_W'(hedsc_pkg::MAX_RESULTS))) ||
                             !hold_valid_reg || out_free;
        status.flush_ok    = !(hold_valid_reg || item_last_reg) || out_free;
    end

    always_comb
    begin
        in_entity_next  = in_entity_reg;
        wcount_next     = wcount_reg;
        cand_next       = cand_reg;
        wstart_next     = wstart_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        pending_next    = pending_reg;
        seen_next       = seen_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_bvalid_next = out_bvalid_reg;
        out_last_next   = out_last_reg;

        if (cmd.step)
        begin
            if (space_only)
            begin
                pending_next = 1'b0;
            end
            else
            begin
                in_entity_next = dec_in_entity;
                wcount_next    = dec_wcount;
                cand_next      = dec_cand;
                wstart_next    = dec_wstart;
                rd_next        = dec_rd;
                wr_next        = dec_wr;
                if (emit_req)
                begin
                    if (is_ws(emit_char))
                    begin
                        pending_next = pending_reg || seen_reg;
                    end
                    else
                    begin
                        pending_next = 1'b0;
                        seen_next    = 1'b1;
                    end
                end
            end
        end

        if (cmd.load)
        begin
            cnt_next = '0;
        end
        else if (keep)
        begin
            cnt_next = cnt_reg + hedsc_pkg::CNT_W'(1);
        end

        if (keep)
        begin
            hold_valid_next = 1'b1;
            hold_byte_next  = res_char;
            if (hold_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = hold_byte_reg;
                out_bvalid_next = 1'b1;
                out_last_next   = 1'b0;
            end
        end

        if (cmd.flush)
        begin
            hold_valid_next = 1'b0;
            if (hold_valid_reg || item_last_reg)
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = hold_valid_reg ? hold_byte_reg : 8'h00;
                out_bvalid_next = hold_valid_reg;
                out_last_next   = item_last_reg;
            end
            if (item_last_reg)
            begin
                in_entity_next = 1'b0;
                wcount_next    = '0;
                pending_next   = 1'b0;
                seen_next      = 1'b0;
                rd_next        = '0;
                wr_next        = '0;
                wstart_next    = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[wr_reg] <= cur_byte;
            fwd_byte_reg    <= cur_byte;
        end
        rd_data_reg <= win_mem[rd_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_byte_reg <= in_byte;
        end
        hold_byte_reg  <= hold_byte_next;
        out_byte_reg   <= out_byte_next;
        out_bvalid_reg <= out_bvalid_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_last_reg  <= 1'b0;
            in_entity_reg  <= 1'b0;
            wcount_reg     <= '0;
            cand_reg       <= '0;
            wstart_reg     <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            pending_reg    <= 1'b0;
            seen_reg       <= 1'b0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                item_last_reg <= in_last;
            end
            in_entity_reg  <= in_entity_next;
            wcount_reg     <= wcount_next;
            cand_reg       <= cand_next;
            wstart_reg     <= wstart_next;
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            pending_reg    <= pending_next;
            seen_reg       <= seen_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            fwd_reg        <= mem_we && (wr_reg == rd_next);
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_byte_valid = out_bvalid_reg;
    assign out_last       = out_last_reg;

    `ASSERT_ALWAYS(a_wcount_range, CMP_W'(wcount_reg) < CMP_W'(WIN_DEPTH), "window overflow")
    `ASSERT_IMPLY(a_closed_window_empty, !in_entity_reg, wcount_reg == '0, "stale window count")
    `ASSERT_ALWAYS(a_result_cap, cnt_reg <= hedsc_pkg::CNT_W'(hedsc_pkg::MAX_RESULTS), "count")
    `ASSERT_IMPLY(a_load_queue_empty, cmd.load, rd_reg == wr_reg, "item taken with replay pending")
    `ASSERT_IMPLY(a_out_no_overwrite, out_push, out_free, "output register overwritten")

endmodule

// ===== src/hedsc_ctrl.sv =====
// Sequencer for item intake, replay of held bytes and end-of-item flush.
`timescale 1ns / 1ps

module hedsc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output hedsc_pkg::dp_cmd_t    cmd,
    input  hedsc_pkg::dp_status_t status
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_INPUT  = 2'd1;
    localparam logic [1:0] S_REPLAY = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.flush  = 1'b0;
        cmd.mode   = hedsc_pkg::MODE_INPUT;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_INPUT;
                end
            end
            S_INPUT:
            begin
                cmd.step = status.slot_ok;
                if (status.slot_ok && !status.space_only)
                begin
                    state_next = S_REPLAY;
                end
            end
            S_REPLAY:
            begin
                if (!status.queue_empty)
                begin
                    cmd.mode = hedsc_pkg::MODE_QUEUE;
                    cmd.step = status.slot_ok;
                end
                else if (status.item_last && status.in_entity)
                begin
                    cmd.mode = hedsc_pkg::MODE_FORCE;
                    cmd.step = status.slot_ok;
                end
                else
                begin
                    cmd.flush = status.flush_ok;
                    if (status.flush_ok)
                    begin
                        in_ready = 1'b1;
                        if (in_valid)
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_INPUT;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/html_entity_decode_space_collapse.sv =====
// Top level: streaming HTML entity decoder with whitespace folding.
// Each result of an item waits in a holding register for the next result or the end of the
// item. Each item takes a decode step, plus an extra step for each replayed byte after a
// failed entity, each owed space and each window closed at the end of a string; the next
// item is taken no earlier than the flush of this one; a stalled output stalls the input.
// Reset: rst_n clears all control state at once; the entity window is not cleared.
`timescale 1ns / 1ps

module html_entity_decode_space_collapse #(
    parameter int MAX_ENTITY_SPAN = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] byte_valid
    output logic       m_axis_tlast
);

    hedsc_pkg::dp_cmd_t    cmd;
    hedsc_pkg::dp_status_t status;

    hedsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    hedsc_datapath #(
        .MAX_ENTITY_SPAN (MAX_ENTITY_SPAN)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_byte        (s_axis_tdata),
        .in_last        (s_axis_tlast),
        .out_valid      (m_axis_tvalid),
        .out_byte       (m_axis_tdata),
        .out_byte_valid (m_axis_tuser),
        .out_last       (m_axis_tlast),
        .out_ready      (m_axis_tready)
    );

endmodule
